/* rtl/core/msta_pkg.sv */
`default_nettype none
package msta_pkg;

    localparam int NUM_ROADS_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    // result status codes
    localparam logic [2:0] ST_PUSHED     = 3'd0;
    localparam logic [2:0] ST_DROPPED    = 3'd1;
    localparam logic [2:0] ST_NOT_ENOUGH = 3'd2;
    localparam logic [2:0] ST_WINDOW     = 3'd3;
    localparam logic [2:0] ST_STALE_LONE = 3'd4;
    localparam logic [2:0] ST_EMPTY      = 3'd5;
    localparam logic [2:0] ST_NEWER      = 3'd6;

    // operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_ALIGN = 1'b1;

    // register indexes
    localparam logic [2:0] REG_MIN_BUFFERED = 3'd0;
    localparam logic [2:0] REG_FRAME_PERIOD = 3'd1;
    localparam logic [2:0] REG_EXTRA_LAG    = 3'd2;
    localparam logic [2:0] REG_WINDOW       = 3'd3;
    localparam logic [2:0] REG_REF_OLDEST   = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [2:0]  road;
        logic [47:0] timestamp;
        logic [31:0] cross_code;
        logic [31:0] payload;
        logic [47:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_road;
        logic [2:0]  status;
        logic [47:0] out_timestamp;
        logic [31:0] out_cross_code;
        logic [31:0] out_payload;
        logic [47:0] reference_time;
        logic [3:0]  discarded;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

/* rtl/core/multi_stream_timestamp_aligner_unit.sv */
// Push: the item is accepted, then the record is written and the result emitted.
// Align: the roads are scanned to find the fullest, the reference is built in
// S_DECIDE, S_REFRD, S_REFCMP and S_WIN, then each road is read and checked, with
// stale entries dropped one by one; one record memory port serves every read and the push write.
// One item at a time; the result register frees the output side meanwhile.
// Reset (rst_n low, asynchronous) empties all roads and restores registers.
`default_nettype none
module multi_stream_timestamp_aligner_unit #(
    parameter int NUM_ROADS   = msta_pkg::NUM_ROADS_DEF,
    parameter int QUEUE_DEPTH = msta_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  msta_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    output msta_pkg::out_item_t  out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [4:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int RW = (NUM_ROADS > 1) ? $clog2(NUM_ROADS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int AW = $clog2(NUM_ROADS * QUEUE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PUSH   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_REFRD  = 4'd4;
    localparam logic [3:0] S_REFCMP = 4'd5;
    localparam logic [3:0] S_WIN    = 4'd6;
    localparam logic [3:0] S_WRD    = 4'd7;
    localparam logic [3:0] S_WCHK   = 4'd8;

    typedef struct packed {
        logic [47:0] ts;
        logic [31:0] code;
        logic [31:0] handle;
    } rec_t;

    function automatic logic [QW-1:0] slot_after(input logic [QW-1:0] p,
                                                 input logic [QW:0] n);
        logic [QW:0] s;
        s = {1'b0, p} + n;
        if (s >= (QW+1)'(QUEUE_DEPTH))
            s = s - (QW+1)'(QUEUE_DEPTH);
        return s[QW-1:0];
    endfunction

    // configuration registers
    logic [4:0]  min_buf_reg;
    logic [15:0] period_reg;
    logic [31:0] lag_reg;
    logic [15:0] window_reg;
    logic        oldest_reg;

    logic [3:0]            state_reg, state_next;
    msta_pkg::in_item_t    item_reg, item_next;
    logic [2:0]            cur_road_reg, cur_road_next;
    logic [2:0]            best_reg, best_next;
    logic [QW:0]           most_reg, most_next;
    logic [3:0]            disc_reg, disc_next;
    logic [20:0]           prod_reg, prod_next;
    logic [47:0]           tmp_reg, tmp_next;
    logic [47:0]           floor_reg, floor_next;
    logic [47:0]           ref_reg, ref_next;
    logic [47:0]           left_reg, left_next;
    logic [47:0]           right_reg, right_next;
    logic [QW-1:0]         head_reg [NUM_ROADS];
    logic [QW-1:0]         head_next [NUM_ROADS];
    logic [QW:0]           fill_reg [NUM_ROADS];
    logic [QW:0]           fill_next [NUM_ROADS];
    logic                  out_valid_reg, out_valid_next;
    msta_pkg::out_item_t   out_data_reg, out_data_next;

    rec_t                  mem [NUM_ROADS * QUEUE_DEPTH];
    rec_t                  rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [QW:0]           off;

    logic [RW-1:0]         ridx;
    logic                  road_ok;
    logic [QW:0]           cur_fill;
    logic [QW-1:0]         cur_head;
    logic                  can_emit;
    logic                  emit;
    msta_pkg::out_item_t   emit_data;
    logic                  at_last;
    logic                  stale;

    assign ridx     = cur_road_reg[RW-1:0];
    assign road_ok  = {1'b0, cur_road_reg} < 4'(NUM_ROADS);
    assign cur_fill = road_ok ? fill_reg[ridx] : '0;
    assign cur_head = road_ok ? head_reg[ridx] : '0;
    assign can_emit = !out_valid_reg || !out_stall;
    assign at_last  = (cur_road_reg == 3'(NUM_ROADS - 1));
    assign stale    = rd_data_reg.ts < left_reg;
    assign mem_addr = AW'(ridx) * AW'(QUEUE_DEPTH) + AW'(slot_after(cur_head, off));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;
    assign pready    = 1'b1;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        cur_road_next = cur_road_reg;
        best_next     = best_reg;
        most_next     = most_reg;
        disc_next     = disc_reg;
        prod_next     = prod_reg;
        tmp_next      = tmp_reg;
        floor_next    = floor_reg;
        ref_next      = ref_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        emit          = 1'b0;
        emit_data     = '0;
        mem_we        = 1'b0;
        off           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next     = in_item;
                    cur_road_next = (in_item.operation == msta_pkg::OP_ALIGN) ?
                                    3'd0 : in_item.road;
                    most_next     = '0;
                    best_next     = '0;
                    state_next    = (in_item.operation == msta_pkg::OP_ALIGN) ?
                                    S_SCAN : S_PUSH;
                end
            end
            S_PUSH:
            begin
                off = cur_fill;
                if (can_emit)
                begin
                    emit               = 1'b1;
                    emit_data.out_road = cur_road_reg;
                    emit_data.last     = 1'b1;
                    if (road_ok && cur_fill < (QW+1)'(QUEUE_DEPTH))
                    begin
                        emit_data.status = msta_pkg::ST_PUSHED;
                        mem_we           = 1'b1;
                        fill_next[ridx]  = cur_fill + 1'b1;
                    end
                    else
                    begin
                        emit_data.status = msta_pkg::ST_DROPPED;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                prod_next = period_reg * min_buf_reg;
                if (cur_fill > most_reg)
                begin
                    most_next = cur_fill;
                    best_next = cur_road_reg;
                end
                if (at_last)
                    state_next = S_DECIDE;
                else
                    cur_road_next = cur_road_reg + 3'd1;
            end
            S_DECIDE:
            begin
                if (most_reg == '0 || {1'b0, most_reg} < 6'(min_buf_reg))
                begin
                    if (can_emit)
                    begin
                        emit               = 1'b1;
                        emit_data.out_road = best_reg;
                        emit_data.status   = msta_pkg::ST_NOT_ENOUGH;
                        emit_data.last     = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    cur_road_next = best_reg;
                    tmp_next      = item_reg.now_ms - 48'(prod_reg);
                    state_next    = S_REFRD;
                end
            end
            S_REFRD:
            begin
                // read the oldest or newest entry of the fullest road
                off        = oldest_reg ? '0 : most_reg - 1'b1;
                floor_next = tmp_reg - 48'(lag_reg);
                state_next = S_REFCMP;
            end
            S_REFCMP:
            begin
                ref_next   = (rd_data_reg.ts < floor_reg) ? floor_reg : rd_data_reg.ts;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                left_next     = ref_reg - 48'(window_reg);
                right_next    = ref_reg + 48'(window_reg);
                cur_road_next = 3'd0;
                disc_next     = '0;
                state_next    = S_WRD;
            end
            S_WRD:
            begin
                if (cur_fill == '0)
                begin
                    if (can_emit)
                    begin
                        emit                     = 1'b1;
                        emit_data.out_road       = cur_road_reg;
                        emit_data.status         = msta_pkg::ST_EMPTY;
                        emit_data.reference_time = ref_reg;
                        emit_data.discarded      = disc_reg;
                        emit_data.last           = at_last;
                        disc_next                = '0;
                        cur_road_next            = cur_road_reg + 3'd1;
                        state_next               = at_last ? S_IDLE : S_WRD;
                    end
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (stale && cur_fill > (QW+1)'(1))
                begin
                    // drop a stale head and look at the next one
                    head_next[ridx] = slot_after(cur_head, (QW+1)'(1));
                    fill_next[ridx] = cur_fill - 1'b1;
                    disc_next       = disc_reg + 4'd1;
                    state_next      = S_WRD;
                end
                else if (can_emit)
                begin
                    emit                     = 1'b1;
                    emit_data.out_road       = cur_road_reg;
                    emit_data.reference_time = ref_reg;
                    emit_data.discarded      = disc_reg;
                    emit_data.last           = at_last;
                    if (stale || rd_data_reg.ts <= right_reg)
                    begin
                        emit_data.status         = stale ? msta_pkg::ST_STALE_LONE :
                                                           msta_pkg::ST_WINDOW;
                        emit_data.out_timestamp  = rd_data_reg.ts;
                        emit_data.out_cross_code = rd_data_reg.code;
                        emit_data.out_payload    = rd_data_reg.handle;
                        head_next[ridx]          = slot_after(cur_head, (QW+1)'(1));
                        fill_next[ridx]          = cur_fill - 1'b1;
                    end
                    else
                    begin
                        emit_data.status = msta_pkg::ST_NEWER;
                    end
                    disc_next     = '0;
                    cur_road_next = cur_road_reg + 3'd1;
                    state_next    = at_last ? S_IDLE : S_WRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold or load the result register
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_road_reg  <= '0;
            best_reg      <= '0;
            most_reg      <= '0;
            disc_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ROADS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_road_reg  <= cur_road_next;
            best_reg      <= best_next;
            most_reg      <= most_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        tmp_reg      <= tmp_next;
        floor_reg    <= floor_next;
        ref_reg      <= ref_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        out_data_reg <= out_data_next;
    end

    // record memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= '{ts: item_reg.timestamp, code: item_reg.cross_code,
                               handle: item_reg.payload};
        rd_data_reg <= mem[mem_addr];
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_buf_reg <= 5'd3;
            period_reg  <= 16'd100;
            lag_reg     <= 32'd0;
            window_reg  <= 16'd50;
            oldest_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                msta_pkg::REG_MIN_BUFFERED: min_buf_reg <= pwdata[4:0];
                msta_pkg::REG_FRAME_PERIOD: period_reg  <= pwdata[15:0];
                msta_pkg::REG_EXTRA_LAG:    lag_reg     <= pwdata;
                msta_pkg::REG_WINDOW:       window_reg  <= pwdata[15:0];
                msta_pkg::REG_REF_OLDEST:   oldest_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            msta_pkg::REG_MIN_BUFFERED: prdata = 32'(min_buf_reg);
            msta_pkg::REG_FRAME_PERIOD: prdata = 32'(period_reg);
            msta_pkg::REG_EXTRA_LAG:    prdata = lag_reg;
            msta_pkg::REG_WINDOW:       prdata = 32'(window_reg);
            msta_pkg::REG_REF_OLDEST:   prdata = 32'(oldest_reg);
            default:                    prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start the sequencer");
    a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WCHK) |-> (cur_fill != '0))
        else $error("head check on an empty road");
    a_most_bound: assert property (@(posedge clk) disable iff (!rst_n)
        most_reg <= (QW+1)'(QUEUE_DEPTH))
        else $error("fullest count beyond queue depth");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("result overwrote a pending item");
`endif

endmodule
`default_nettype wire

/* bench/multi_stream_timestamp_aligner_unit_tb.sv */
`timescale 1ns / 100ps
module multi_stream_timestamp_aligner_unit_tb;

    localparam int ROADS = 4;
    localparam int DEPTH = 16;
    localparam logic [47:0] TS_MASK = 48'hFFFF_FFFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    msta_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    msta_pkg::out_item_t out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // stimulus and expected results
    msta_pkg::in_item_t  pending_q[$];
    msta_pkg::out_item_t expected_q[$];
    int          error_count = 0;
    logic        burst_mode = 1'b0;
    logic        out_hold = 1'b0;
    int          in_gap = 0;
    int          out_wait = 0;
    logic [47:0] time_base;

    // shadow of the block state
    logic [47:0] road_time[ROADS][DEPTH];
    logic [31:0] road_code[ROADS][DEPTH];
    logic [31:0] road_handle[ROADS][DEPTH];
    int          road_head[ROADS];
    int          road_fill[ROADS];
    logic [4:0]  cfg_min;
    logic [15:0] cfg_period;
    logic [31:0] cfg_lag;
    logic [15:0] cfg_window;
    logic        cfg_oldest;

    multi_stream_timestamp_aligner_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    function automatic msta_pkg::out_item_t make_result(int road, logic [2:0] st,
                                                        logic [47:0] ts,
                                                        logic [31:0] code, logic [31:0] pay,
                                                        logic [47:0] ref_ts, int disc,
                                                        logic fin);
        msta_pkg::out_item_t r;
        r.out_road       = road[2:0];
        r.status         = st;
        r.out_timestamp  = ts;
        r.out_cross_code = code;
        r.out_payload    = pay;
        r.reference_time = ref_ts;
        r.discarded      = disc[3:0];
        r.last           = fin;
        return r;
    endfunction

    // compute the results of one accepted item and update the shadow state
    function automatic void predict_item(msta_pkg::in_item_t it);
        int          best;
        int          most;
        int          slot;
        int          disc;
        logic [47:0] pick;
        logic [47:0] floor_ts;
        logic [47:0] ref_ts;
        logic [47:0] left;
        logic [47:0] right;
        logic [47:0] h;
        logic [63:0] span;
        best = 0;
        most = 0;
        if (it.operation == msta_pkg::OP_PUSH) begin
            if (it.road >= ROADS || road_fill[it.road] >= DEPTH) begin
                expected_q.push_back(make_result(it.road, msta_pkg::ST_DROPPED,
                                                 '0, '0, '0, '0, 0, 1'b1));
                return;
            end
            slot = (road_head[it.road] + road_fill[it.road]) % DEPTH;
            road_time[it.road][slot]   = it.timestamp;
            road_code[it.road][slot]   = it.cross_code;
            road_handle[it.road][slot] = it.payload;
            road_fill[it.road]++;
            expected_q.push_back(make_result(it.road, msta_pkg::ST_PUSHED,
                                             '0, '0, '0, '0, 0, 1'b1));
            return;
        end
        for (int r = 0; r < ROADS; r++) begin
            if (road_fill[r] > most) begin
                most = road_fill[r];
                best = r;
            end
        end
        if (most == 0 || most < cfg_min) begin
            expected_q.push_back(make_result(best, msta_pkg::ST_NOT_ENOUGH,
                                             '0, '0, '0, '0, 0, 1'b1));
            return;
        end
        if (cfg_oldest)
            pick = road_time[best][road_head[best]];
        else
            pick = road_time[best][(road_head[best] + most - 1) % DEPTH];
        span = 64'(cfg_period) * 64'(cfg_min) + 64'(cfg_lag);
        floor_ts = (it.now_ms - span[47:0]) & TS_MASK;
        ref_ts = (pick < floor_ts) ? floor_ts : pick;
        left  = ref_ts - 48'(cfg_window);
        right = ref_ts + 48'(cfg_window);
        for (int r = 0; r < ROADS; r++) begin
            disc = 0;
            forever begin
                if (road_fill[r] == 0) begin
                    expected_q.push_back(make_result(r, msta_pkg::ST_EMPTY, '0, '0, '0,
                                                     ref_ts, disc, r == ROADS - 1));
                    break;
                end
                slot = road_head[r];
                h = road_time[r][slot];
                // drop stale heads while more remain behind them
                if (h < left && road_fill[r] > 1) begin
                    road_head[r] = (slot + 1) % DEPTH;
                    road_fill[r]--;
                    disc++;
                    continue;
                end
                if (h < left || h <= right) begin
                    road_head[r] = (slot + 1) % DEPTH;
                    road_fill[r]--;
                    expected_q.push_back(make_result(r, (h < left) ? msta_pkg::ST_STALE_LONE :
                                                                     msta_pkg::ST_WINDOW,
                                                     h, road_code[r][slot], road_handle[r][slot],
                                                     ref_ts, disc, r == ROADS - 1));
                    break;
                end
                expected_q.push_back(make_result(r, msta_pkg::ST_NEWER, '0, '0, '0, ref_ts,
                                                 disc, r == ROADS - 1));
                break;
            end
        end
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // offer pending items, predict on acceptance, then idle for a random gap unless in burst mode
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        logic taken;
        int   gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            gap = in_gap;
            if (taken)
            begin
                predict_item(in_item);
                void'(pending_q.pop_front());
                gap = burst_mode ? 0 : $urandom_range(0, 7);
            end
            if (in_valid && !taken)
                ;
            else if (gap != 0)
            begin
                in_valid <= 1'b0;
                gap--;
            end
            else if (pending_q.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item  <= pending_q[0];
            end
            else
                in_valid <= 1'b0;
            in_gap <= gap;
        end
    end

    // compare each accepted result with the oldest expectation, then stall at random
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        msta_pkg::out_item_t want;
        int                  cnt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait  <= 0;
        end
        else
        begin
            cnt = out_wait;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_road", want.out_road, out_item.out_road);
                    check_field("status", want.status, out_item.status);
                    check_field("out_timestamp", want.out_timestamp, out_item.out_timestamp);
                    check_field("out_cross_code", want.out_cross_code, out_item.out_cross_code);
                    check_field("out_payload", want.out_payload, out_item.out_payload);
                    check_field("reference_time", want.reference_time,
                                out_item.reference_time);
                    check_field("discarded", want.discarded, out_item.discarded);
                    check_field("last", want.last, out_item.last);
                end
                cnt = burst_mode ? 0 : $urandom_range(0, 7);
            end
            else if (cnt != 0)
                cnt--;
            out_stall <= (cnt != 0) || out_hold;
            out_wait  <= cnt;
        end
    end

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            msta_pkg::REG_MIN_BUFFERED: cfg_min    = value[4:0];
            msta_pkg::REG_FRAME_PERIOD: cfg_period = value[15:0];
            msta_pkg::REG_EXTRA_LAG:    cfg_lag    = value;
            msta_pkg::REG_WINDOW:       cfg_window = value[15:0];
            msta_pkg::REG_REF_OLDEST:   cfg_oldest = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] min_v, logic [31:0] period, logic [31:0] lag,
                              logic [31:0] win, logic [31:0] oldest);
        reg_write(msta_pkg::REG_MIN_BUFFERED, min_v);
        reg_write(msta_pkg::REG_FRAME_PERIOD, period);
        reg_write(msta_pkg::REG_EXTRA_LAG, lag);
        reg_write(msta_pkg::REG_WINDOW, win);
        reg_write(msta_pkg::REG_REF_OLDEST, oldest);
    endtask

    function automatic msta_pkg::in_item_t push_item(logic [2:0] road, logic [47:0] ts,
                                                     logic [31:0] code, logic [31:0] pay);
        msta_pkg::in_item_t it;
        it.operation  = msta_pkg::OP_PUSH;
        it.road       = road;
        it.timestamp  = ts;
        it.cross_code = code;
        it.payload    = pay;
        it.now_ms     = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic msta_pkg::in_item_t align_item(logic [47:0] now);
        msta_pkg::in_item_t it;
        it.operation  = msta_pkg::OP_ALIGN;
        it.road       = 3'($urandom);
        it.timestamp  = 48'({$urandom, $urandom});
        it.cross_code = $urandom;
        it.payload    = $urandom;
        it.now_ms     = now;
        return it;
    endfunction

    // queue a random mix of pushes, alignments and raw items around a moving clock
    task automatic queue_stream(int count);
        msta_pkg::in_item_t it;
        logic [191:0]       raw;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                it  = raw[$bits(msta_pkg::in_item_t)-1:0];
            end
            else if (pick < 24)
                it = align_item(time_base + 48'($urandom_range(0, 300)));
            else
                it = push_item(3'($urandom_range(0, ROADS - 1)),
                               time_base - 48'd150 + 48'($urandom_range(0, 300)),
                               $urandom, $urandom);
            pending_q.push_back(it);
            time_base = time_base + 48'($urandom_range(0, 60));
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < ROADS; r++) begin
            road_head[r] = 0;
            road_fill[r] = 0;
        end
        cfg_min    = 5'd3;
        cfg_period = 16'd100;
        cfg_lag    = 32'd0;
        cfg_window = 16'd50;
        cfg_oldest = 1'b1;
        time_base  = 48'({$urandom, $urandom});
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty align, bad roads, field extremes, both reference modes
        pending_q.push_back(align_item('0));
        pending_q.push_back(push_item(3'd7, TS_MASK, '1, '1));
        pending_q.push_back(push_item(3'd4, '0, '0, '0));
        pending_q.push_back(push_item(3'd0, 48'd1000, '1, '1));
        pending_q.push_back(push_item(3'd0, 48'd1040, 32'h0, 32'h0));
        pending_q.push_back(align_item(48'd1100));
        pending_q.push_back(push_item(3'd0, 48'd1200, 32'h1234_5678, 32'h9abc_def0));
        pending_q.push_back(push_item(3'd1, 48'd10, 32'h1, 32'h2));
        pending_q.push_back(push_item(3'd1, 48'd20, 32'h3, 32'h4));
        pending_q.push_back(push_item(3'd1, 48'd1010, 32'h5, 32'h6));
        pending_q.push_back(push_item(3'd2, 48'd5000, 32'h7, 32'h8));
        pending_q.push_back(push_item(3'd3, 48'd30, 32'h9, 32'ha));
        pending_q.push_back(align_item(48'd1100));
        pending_q.push_back(align_item(48'd1100));
        pending_q.push_back(push_item(3'd2, TS_MASK, 32'hb, 32'hc));
        pending_q.push_back(push_item(3'd2, 48'd5, 32'hd, 32'he));
        pending_q.push_back(align_item(48'd20));
        wait_drained();

        set_config(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        pending_q.push_back(push_item(3'd3, 48'd40, 32'h11, 32'h22));
        pending_q.push_back(align_item(TS_MASK));
        pending_q.push_back(align_item(48'd0));
        wait_drained();

        // random phases across register settings
        queue_stream(60);
        wait_drained();

        set_config(32'd16, 32'd65535, 32'hFFFF_FFFF, 32'd65535, 32'd1);
        burst_mode <= 1'b1;
        queue_stream(50);
        wait_drained();
        burst_mode <= 1'b0;

        set_config(32'd0, 32'd30, 32'd100, 32'd80, 32'd1);
        queue_stream(40);
        wait_drained();

        set_config(32'd2, 32'd40, 32'd20, 32'd60, 32'd0);
        queue_stream(60);
        wait_drained();

        // hold the output side while one road floods past its depth
        set_config(32'd4, 32'd25, 32'd0, 32'd100, 32'd1);
        out_hold <= 1'b1;
        for (int i = 0; i < 20; i++)
            pending_q.push_back(push_item(3'd2, time_base + 48'(i * 30), $urandom, $urandom));
        pending_q.push_back(align_item(time_base + 48'd100));
        queue_stream(20);
        repeat (400) @(posedge clk);
        out_hold <= 1'b0;
        wait_drained();

        set_config(32'd3, 32'd100, 32'd0, 32'd50, 32'd1);
        queue_stream(60);
        wait_drained();

        set_config(32'd31, 32'd1, 32'd1, 32'd1, 32'd0);
        queue_stream(20);
        wait_drained();

        set_config(32'd1, 32'd10, 32'd5, 32'd200, 32'd0);
        queue_stream(30);
        wait_drained();

        if (error_count == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
rtl/core/msta_pkg.sv
rtl/core/multi_stream_timestamp_aligner_unit.sv
bench/multi_stream_timestamp_aligner_unit_tb.sv
